@@ src/hbf_pkg.sv @@
// Shared types, constants and saturation helpers for the harmonic bond force accumulator.
package hbf_pkg;

   localparam int ACT_W  = 2;
   localparam int ATOM_W = 12;
   localparam int POS_W  = 32;
   localparam int ACC_W  = 48;
   localparam int PROD_W = 64;
   localparam int ITER_W = 6;

   localparam logic [ITER_W-1:0] SQRT_STEPS = ITER_W'(32);
   localparam logic [ITER_W-1:0] DIV_STEPS  = ITER_W'(48);

   localparam logic signed [PROD_W-1:0] ONE_Q16 = PROD_W'(65536);
   localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
   localparam logic signed [ACC_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [ACC_W-1:0] MIN48 = 48'sh8000_0000_0000;

   typedef enum logic [ACT_W-1:0] {
      ACT_APPLY = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE,
      ST_MUL_X, ST_MUL_Y, ST_MUL_Z, ST_SUM, ST_CHK,
      ST_SQRT, ST_DIV_INIT, ST_DIV,
      ST_T_CAP, ST_MUL_RK, ST_S_CAP, ST_MUL_FX, ST_MUL_FY, ST_MUL_FZ, ST_F_CAP,
      ST_WR_I, ST_RD_J, ST_WR_J,
      ST_RD, ST_CLR, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_DX, MUL_DY, MUL_DZ, MUL_RK, MUL_FX, MUL_FY, MUL_FZ
   } mul_sel_type;

   typedef enum logic [1:0] {
      WR_SWEEP, WR_CLR_I, WR_ADD_I, WR_SUB_J
   } wr_sel_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } force_vec_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        rsq_load;
      logic        rsq_add;
      logic        sqrt_init;
      logic        sqrt_step;
      logic        div_init;
      logic        div_step;
      logic        t_load;
      logic        s_load;
      logic        fx_load;
      logic        fy_load;
      logic        fz_load;
      logic        mem_rd;
      logic        rd_j;
      logic        mem_wr;
      wr_sel_type  wr_sel;
      logic        sweep_step;
      logic        rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsq_zero;
      logic iter_last;
      logic sweep_last;
      logic slot_free;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
      if (v > PROD_W'(MAX32)) return MAX32;
      if (v < PROD_W'(MIN32)) return MIN32;
      return v[31:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add48(input logic signed [ACC_W-1:0] a,
                                                         input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] sum;
      sum = (ACC_W+1)'(a) + (ACC_W+1)'(b);
      if (sum[ACC_W] != sum[ACC_W-1]) return sum[ACC_W] ? MIN48 : MAX48;
      return sum[ACC_W-1:0];
   endfunction

endpackage

@@ src/hbf_force_mem.sv @@
// Per-atom force store: one write port, one registered read port.
module hbf_force_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  hbf_pkg::force_vec_type wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output hbf_pkg::force_vec_type rd_data
);
   import hbf_pkg::*;

   force_vec_type mem [DEPTH];
   force_vec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/hbf_ctrl.sv @@
// Sequencer for apply, read and clear actions and the post-reset clearing sweep.
module hbf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_action,
   output logic                  req_ready,
   input  hbf_pkg::dp_status_type status,
   output hbf_pkg::ctrl_cmd_type  cmd
);
   import hbf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_sel = MUL_DX;
      cmd.wr_sel  = WR_SWEEP;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.mem_wr     = 1'b1;
            cmd.wr_sel     = WR_SWEEP;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_action == ACT_APPLY)      state_in = ST_MUL_X;
               else if (req_action == ACT_READ)  state_in = ST_RD;
               else if (req_action == ACT_CLEAR) state_in = ST_CLR;
               else                              state_in = ST_DONE;
            end
         end
         ST_MUL_X: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DX;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.rsq_load = 1'b1;
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DY;
            state_in = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            cmd.rsq_add = 1'b1;
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_DZ;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.rsq_add = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.sqrt_init = 1'b1;
            state_in = status.rsq_zero ? ST_DONE : ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.iter_last) state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.iter_last) state_in = ST_T_CAP;
         end
         ST_T_CAP: begin
            cmd.t_load = 1'b1;
            state_in = ST_MUL_RK;
         end
         ST_MUL_RK: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_RK;
            state_in = ST_S_CAP;
         end
         ST_S_CAP: begin
            cmd.s_load = 1'b1;
            state_in = ST_MUL_FX;
         end
         ST_MUL_FX: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_FX;
            state_in = ST_MUL_FY;
         end
         ST_MUL_FY: begin
            cmd.fx_load = 1'b1;
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_FY;
            state_in = ST_MUL_FZ;
         end
         ST_MUL_FZ: begin
            cmd.fy_load = 1'b1;
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_FZ;
            state_in = ST_F_CAP;
         end
         ST_F_CAP: begin
            cmd.fz_load = 1'b1;
            cmd.mem_rd  = 1'b1;
            state_in = ST_WR_I;
         end
         ST_WR_I: begin
            cmd.mem_wr = 1'b1; cmd.wr_sel = WR_ADD_I;
            state_in = ST_RD_J;
         end
         ST_RD_J: begin
            // read of j follows the write of i, so i == j sees the updated entry
            cmd.mem_rd = 1'b1; cmd.rd_j = 1'b1;
            state_in = ST_WR_J;
         end
         ST_WR_J: begin
            cmd.mem_wr = 1'b1; cmd.wr_sel = WR_SUB_J;
            state_in = ST_DONE;
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in = ST_DONE;
         end
         ST_CLR: begin
            cmd.mem_wr = 1'b1; cmd.wr_sel = WR_CLR_I;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ src/hbf_datapath.sv @@
// Datapath: operand registers, shared multiplier, root and divide recurrences, force store, result.
module hbf_datapath #(
   parameter int NUM_ATOMS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hbf_pkg::ctrl_cmd_type  cmd,
   output hbf_pkg::dp_status_type status,
   input  logic [1:0]            req_action,
   input  logic [11:0]           req_atom_i,
   input  logic [11:0]           req_atom_j,
   input  logic signed [31:0]    req_pos_ix,
   input  logic signed [31:0]    req_pos_iy,
   input  logic signed [31:0]    req_pos_iz,
   input  logic signed [31:0]    req_pos_jx,
   input  logic signed [31:0]    req_pos_jy,
   input  logic signed [31:0]    req_pos_jz,
   input  logic [31:0]           req_rest_length,
   input  logic signed [31:0]    req_stiffness,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [47:0]    rsp_force_x,
   output logic signed [47:0]    rsp_force_y,
   output logic signed [47:0]    rsp_force_z,
   output logic signed [47:0]    rsp_scalar_sum,
   output logic                  rsp_degenerate
);
   import hbf_pkg::*;

   localparam int AW   = (NUM_ATOMS > 1) ? $clog2(NUM_ATOMS) : 1;
   localparam int EXTW = (AW > ATOM_W) ? AW : ATOM_W;

   // captured item
   logic [ACT_W-1:0]        action_ff;
   logic [AW-1:0]           addr_i_ff, addr_j_ff;
   logic                    range_i_ff, range_j_ff;
   logic signed [31:0]      dx_ff, dy_ff, dz_ff, rk_ff;
   logic [31:0]             r0_ff;
   logic [EXTW-1:0]         ext_i, ext_j;

   // arithmetic state
   logic signed [PROD_W-1:0] product_ff;
   logic signed [31:0]       op_a, op_b;
   logic [PROD_W-1:0]        rsq_ff;
   logic [PROD_W-1:0]        rem_ff, root_ff, bit_ff, trial;
   logic [ACC_W-1:0]         quot_ff;
   logic [31:0]              drem_ff;
   logic [32:0]              dshift;
   logic [ITER_W-1:0]        iter_ff;
   logic signed [31:0]       t_ff, s_ff;
   logic signed [ACC_W-1:0]  fx_ff, fy_ff, fz_ff;
   logic signed [ACC_W-1:0]  total_ff, total_in;
   logic [AW-1:0]            sweep_ff;

   // store access
   logic                     mem_wr_en;
   logic [AW-1:0]            mem_wr_addr, mem_rd_addr;
   force_vec_type            mem_wr_data, mem_rd_data, rsp_vec;

   // result register
   logic                     rsp_valid_ff;
   logic signed [ACC_W-1:0]  rsp_fx_ff, rsp_fy_ff, rsp_fz_ff, rsp_sum_ff;
   logic                     rsp_degen_ff, rsp_degen;

   assign ext_i = EXTW'(req_atom_i);
   assign ext_j = EXTW'(req_atom_j);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff  <= req_action;
         addr_i_ff  <= ext_i[AW-1:0];
         addr_j_ff  <= ext_j[AW-1:0];
         range_i_ff <= 32'(req_atom_i) < 32'(NUM_ATOMS);
         range_j_ff <= 32'(req_atom_j) < 32'(NUM_ATOMS);
         dx_ff <= sat32(PROD_W'(req_pos_ix) - PROD_W'(req_pos_jx));
         dy_ff <= sat32(PROD_W'(req_pos_iy) - PROD_W'(req_pos_jy));
         dz_ff <= sat32(PROD_W'(req_pos_iz) - PROD_W'(req_pos_jz));
         r0_ff <= req_rest_length;
         rk_ff <= req_stiffness;
      end
   end

   // shared multiplier operand select
   always_comb begin
      op_a = dx_ff;
      op_b = dx_ff;
      case (cmd.mul_sel)
         MUL_DX: begin op_a = dx_ff; op_b = dx_ff; end
         MUL_DY: begin op_a = dy_ff; op_b = dy_ff; end
         MUL_DZ: begin op_a = dz_ff; op_b = dz_ff; end
         MUL_RK: begin op_a = rk_ff; op_b = t_ff;  end
         MUL_FX: begin op_a = dx_ff; op_b = s_ff;  end
         MUL_FY: begin op_a = dy_ff; op_b = s_ff;  end
         MUL_FZ: begin op_a = dz_ff; op_b = s_ff;  end
         default: begin op_a = dx_ff; op_b = dx_ff; end
      endcase
   end

   assign trial  = root_ff + bit_ff;
   assign dshift = {drem_ff, quot_ff[ACC_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.mul_en) product_ff <= op_a * op_b;
      if (cmd.rsq_load)     rsq_ff <= unsigned'(product_ff);
      else if (cmd.rsq_add) rsq_ff <= rsq_ff + unsigned'(product_ff);

      // bitwise integer square root, two radicand bits per step
      if (cmd.sqrt_init) begin
         rem_ff  <= rsq_ff;
         root_ff <= '0;
         bit_ff  <= PROD_W'(1) << (PROD_W - 2);
         iter_ff <= SQRT_STEPS - ITER_W'(1);
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff  <= bit_ff >> 2;
         iter_ff <= iter_ff - ITER_W'(1);
      end

      // restoring divide of r0 * 2^16 by the root, one quotient bit per step
      if (cmd.div_init) begin
         quot_ff <= {r0_ff, 16'd0};
         drem_ff <= '0;
         iter_ff <= DIV_STEPS - ITER_W'(1);
      end else if (cmd.div_step) begin
         if (dshift >= {1'b0, root_ff[31:0]}) begin
            drem_ff <= 32'(dshift - {1'b0, root_ff[31:0]});
            quot_ff <= {quot_ff[ACC_W-2:0], 1'b1};
         end else begin
            drem_ff <= dshift[31:0];
            quot_ff <= {quot_ff[ACC_W-2:0], 1'b0};
         end
         iter_ff <= iter_ff - ITER_W'(1);
      end

      if (cmd.t_load)  t_ff  <= sat32(signed'(PROD_W'(quot_ff)) - ONE_Q16);
      if (cmd.s_load)  s_ff  <= sat32(product_ff >>> 16);
      if (cmd.fx_load) fx_ff <= product_ff[PROD_W-1:16];
      if (cmd.fy_load) fy_ff <= product_ff[PROD_W-1:16];
      if (cmd.fz_load) fz_ff <= product_ff[PROD_W-1:16];
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_ff <= sweep_ff + AW'(1);
      end
   end

   // force store port muxing
   always_comb begin
      mem_rd_addr = cmd.rd_j ? addr_j_ff : addr_i_ff;
      mem_wr_addr = addr_i_ff;
      mem_wr_data = '0;
      mem_wr_en   = 1'b0;
      case (cmd.wr_sel)
         WR_SWEEP: begin
            mem_wr_addr = sweep_ff;
            mem_wr_en   = cmd.mem_wr;
         end
         WR_CLR_I: begin
            mem_wr_en   = cmd.mem_wr && range_i_ff;
         end
         WR_ADD_I: begin
            mem_wr_data.x = sat_add48(mem_rd_data.x, fx_ff);
            mem_wr_data.y = sat_add48(mem_rd_data.y, fy_ff);
            mem_wr_data.z = sat_add48(mem_rd_data.z, fz_ff);
            mem_wr_en     = cmd.mem_wr && range_i_ff;
         end
         WR_SUB_J: begin
            mem_wr_addr   = addr_j_ff;
            mem_wr_data.x = sat_add48(mem_rd_data.x, -fx_ff);
            mem_wr_data.y = sat_add48(mem_rd_data.y, -fy_ff);
            mem_wr_data.z = sat_add48(mem_rd_data.z, -fz_ff);
            mem_wr_en     = cmd.mem_wr && range_j_ff;
         end
         default: mem_wr_en = 1'b0;
      endcase
   end

   hbf_force_mem #(
      .DEPTH (NUM_ATOMS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (cmd.mem_rd),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // result formation
   always_comb begin
      rsp_vec   = '0;
      rsp_degen = 1'b0;
      total_in  = total_ff;
      case (action_ff)
         ACT_APPLY: begin
            if (rsq_ff == '0) begin
               rsp_degen = 1'b1;
            end else begin
               rsp_vec.x = fx_ff;
               rsp_vec.y = fy_ff;
               rsp_vec.z = fz_ff;
               total_in  = sat_add48(total_ff, ACC_W'(s_ff));
            end
         end
         ACT_READ: begin
            if (range_i_ff) rsp_vec = mem_rd_data;
         end
         ACT_CLEAR: begin
            total_in = '0;
         end
         default: total_in = total_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            total_ff     <= total_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_fx_ff    <= rsp_vec.x;
         rsp_fy_ff    <= rsp_vec.y;
         rsp_fz_ff    <= rsp_vec.z;
         rsp_sum_ff   <= total_in;
         rsp_degen_ff <= rsp_degen;
      end
   end

   assign status.rsq_zero   = (rsq_ff == '0);
   assign status.iter_last  = (iter_ff == '0);
   assign status.sweep_last = (sweep_ff == AW'(NUM_ATOMS - 1));
   assign status.slot_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_force_x    = rsp_fx_ff;
   assign rsp_force_y    = rsp_fy_ff;
   assign rsp_force_z    = rsp_fz_ff;
   assign rsp_scalar_sum = rsp_sum_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule

@@ src/harmonic_bond_force_accumulator.sv @@
// Top level of the harmonic bond force accumulator.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | action, atom_i/j, positions, r0, rk
//   rsp     | out       | rsp_valid/rsp_ready  | force_x/y/z, scalar_sum, degenerate
//
// Apply runs three squarings on the shared multiplier, 32 square-root steps, 48 divide
// steps, four more products and a read-modify-write of entry i then entry j. Read and
// clear make a single store access, an unused code goes straight to the last state, and
// coincident atoms end after the squarings; req_ready returns in the cycle after the
// result loads. After reset a clearing pass zeroes every store entry with req_ready low.
// One item is in flight; the result register holds a finished result while the next
// item is taken, and a second result waits in the last state until rsp_ready.
module harmonic_bond_force_accumulator #(
   parameter int NUM_ATOMS = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [11:0]         req_atom_i,
   input  logic [11:0]         req_atom_j,
   input  logic signed [31:0]  req_pos_ix,
   input  logic signed [31:0]  req_pos_iy,
   input  logic signed [31:0]  req_pos_iz,
   input  logic signed [31:0]  req_pos_jx,
   input  logic signed [31:0]  req_pos_jy,
   input  logic signed [31:0]  req_pos_jz,
   input  logic [31:0]         req_rest_length,
   input  logic signed [31:0]  req_stiffness,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [47:0]  rsp_force_x,
   output logic signed [47:0]  rsp_force_y,
   output logic signed [47:0]  rsp_force_z,
   output logic signed [47:0]  rsp_scalar_sum,
   output logic                rsp_degenerate
);
   import hbf_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   hbf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   hbf_datapath #(
      .NUM_ATOMS (NUM_ATOMS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_atom_i      (req_atom_i),
      .req_atom_j      (req_atom_j),
      .req_pos_ix      (req_pos_ix),
      .req_pos_iy      (req_pos_iy),
      .req_pos_iz      (req_pos_iz),
      .req_pos_jx      (req_pos_jx),
      .req_pos_jy      (req_pos_jy),
      .req_pos_jz      (req_pos_jz),
      .req_rest_length (req_rest_length),
      .req_stiffness   (req_stiffness),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_force_x     (rsp_force_x),
      .rsp_force_y     (rsp_force_y),
      .rsp_force_z     (rsp_force_z),
      .rsp_scalar_sum  (rsp_scalar_sum),
      .rsp_degenerate  (rsp_degenerate)
   );

endmodule

@@ src/hbf_checker.sv @@
// Port-level checks for the harmonic bond force accumulator, bound to the top level.
module hbf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_force_x,
   input logic signed [47:0] rsp_force_y,
   input logic signed [47:0] rsp_force_z,
   input logic signed [47:0] rsp_scalar_sum,
   input logic               rsp_degenerate
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_x) &&
      $stable(rsp_force_y) && $stable(rsp_force_z) && $stable(rsp_scalar_sum))
      else $error("result changed while stalled");

   // coincident atoms never report a force
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
      rsp_force_x == 48'sd0 && rsp_force_y == 48'sd0 && rsp_force_z == 48'sd0)
      else $error("degenerate result carries a force");

   // clearing pass keeps the input closed right after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input open during clearing pass");

   // one item at a time
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transfer while busy");

endmodule

bind harmonic_bond_force_accumulator hbf_checker u_hbf_checker (.*);
